/* design/ftsf_pkg.sv */
// Shared types and constants of the force/torque smoothing filter.
// No dependencies; every other file of the block uses this package.
package ftsf_pkg;

  // Geometry of the channel store
  localparam int NumChannels = 4;
  localparam int Axes        = 3;

  // Field widths
  localparam int ChanW   = 2;
  localparam int DataW   = 32;
  localparam int ThrW    = 31;
  localparam int BlendW  = 16;
  localparam int CfgIdxW = 1;

  // Register reset values: threshold 5.0 in Q15.16, blend about 0.1 in Q0.16
  localparam logic [ThrW-1:0]   JumpThresholdRst = 31'd327680;
  localparam logic [BlendW-1:0] BlendFactorRst   = 16'd6554;
  localparam logic [2*ThrW-1:0] JumpThr2Rst      =
    (2*ThrW)'(JumpThresholdRst) * (2*ThrW)'(JumpThresholdRst);

  typedef logic signed [DataW-1:0] sample_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgJumpThreshold = 1'b0,
    CfgBlendFactor   = 1'b1
  } cfg_idx_e;

  // Input word: one tagged three-axis sample
  typedef struct packed {
    logic [ChanW-1:0] channel;
    sample_t          sample_x;
    sample_t          sample_y;
    sample_t          sample_z;
  } in_word_t;

  // Output word: one filtered three-axis vector
  typedef struct packed {
    logic [ChanW-1:0] out_channel;
    sample_t          out_x;
    sample_t          out_y;
    sample_t          out_z;
    logic             passed_through;
  } out_word_t;

endpackage

/* design/ftsf_in_if.sv */
// Valid/ready channel that carries sample words into the filter.
// Depends on ftsf_pkg for the word type.
interface ftsf_in_if;
  logic               valid;
  logic               ready;
  ftsf_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/ftsf_out_if.sv */
// Valid/ready channel that carries filtered words out of the filter.
// Depends on ftsf_pkg for the word type.
interface ftsf_out_if;
  logic                valid;
  logic                ready;
  ftsf_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/force_torque_smoothing_filter_unit.sv */
// Force/torque smoothing filter. Each input word is a signed Q15.16 three-axis sample tagged
// with a channel (left force, left torque, right force, right torque). The block keeps the
// last smoothed vector of each channel (zero after reset). If the squared distance between
// sample and stored vector is at least the squared jump threshold, the sample is sent out
// unchanged with passed_through set; otherwise the output is stored + floor(blend * (sample -
// stored) / 2^16). The output becomes the channel's new stored vector. Rate: one word per
// clock while the output is ready; a word passes the input register, then the result register.
// The store is read, blended and written back as the word enters the result register, so
// each sample sees the vector left by the last word of its channel. An output register parts
// the two sides; a new word is taken while a result waits if the input register is empty.
// The user must write registers on the plain port only while no word is in flight (unenforced).
// Depends on ftsf_pkg, ftsf_in_if and ftsf_out_if.
module force_torque_smoothing_filter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ftsf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ftsf_pkg::ThrW-1:0]     cfg_wdata_i,
  ftsf_in_if.sink                       in_i,
  ftsf_out_if.source                    out_o
);

  localparam int DW = ftsf_pkg::DataW;
  localparam int TW = ftsf_pkg::ThrW;
  localparam int BW = ftsf_pkg::BlendW;
  localparam int NA = ftsf_pkg::Axes;

  // Configuration registers
  logic [TW-1:0]   thr_q;
  logic [2*TW-1:0] thr2_q;
  logic [BW-1:0]   alpha_q;

  // Pipeline registers
  logic                 s1_valid_q;
  ftsf_pkg::in_word_t   s1_q;
  logic                 out_valid_q;
  ftsf_pkg::out_word_t  res_q;
  ftsf_pkg::out_word_t  res_d;

  // Smoothed vector of each channel
  ftsf_pkg::sample_t store_q [ftsf_pkg::NumChannels][NA];

  // Datapath signals
  logic                          chan_ok;
  ftsf_pkg::sample_t             smp    [NA];
  ftsf_pkg::sample_t             prev   [NA];
  logic signed [DW:0]            diff   [NA];
  logic [DW:0]                   mag    [NA];
  logic [2*TW-1:0]               sq     [NA];
  logic signed [DW+BW+1:0]       prod   [NA];
  ftsf_pkg::sample_t             result [NA];
  logic [63:0]                   dist2;
  logic                          far;

  logic adv;
  logic in_acc;
  logic xfer;

  // Handshake: the result register frees when empty or taken
  assign adv         = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign xfer        = s1_valid_q && adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  // Write configuration registers; keep the squared threshold alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ftsf_pkg::JumpThresholdRst;
      thr2_q  <= ftsf_pkg::JumpThr2Rst;
      alpha_q <= ftsf_pkg::BlendFactorRst;
    end else if (cfg_we_i) begin
      unique case (ftsf_pkg::cfg_idx_e'(cfg_idx_i))
        ftsf_pkg::CfgJumpThreshold: begin
          thr_q  <= cfg_wdata_i;
          thr2_q <= (2*TW)'(cfg_wdata_i) * (2*TW)'(cfg_wdata_i);
        end
        ftsf_pkg::CfgBlendFactor: begin
          alpha_q <= cfg_wdata_i[BW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Valid bits of the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Capture the input word and the result word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_i.data;
    end
    if (xfer) begin
      res_q <= res_d;
    end
  end

  // Read the channel's stored vector and form differences, squares and blend steps
  always_comb begin
    chan_ok = int'(s1_q.channel) < ftsf_pkg::NumChannels;
    smp[0]  = s1_q.sample_x;
    smp[1]  = s1_q.sample_y;
    smp[2]  = s1_q.sample_z;
    far     = !chan_ok;
    dist2   = '0;
    for (int k = 0; k < NA; k++) begin
      prev[k]   = store_q[s1_q.channel][k];
      diff[k]   = {smp[k][DW-1], smp[k]} - {prev[k][DW-1], prev[k]};
      mag[k]    = diff[k][DW] ? (DW+1)'(-diff[k]) : diff[k];
      far       = far || (mag[k] >= (DW+1)'(thr_q));
      sq[k]     = (2*TW)'(mag[k][TW-1:0]) * (2*TW)'(mag[k][TW-1:0]);
      dist2     = dist2 + 64'(sq[k]);
      prod[k]   = diff[k] * $signed({1'b0, alpha_q});
    end
    far = far || (dist2 >= 64'(thr2_q));
    // Blend stays between stored and sample, so the low word of the sum is exact
    for (int k = 0; k < NA; k++) begin
      result[k] = far ? smp[k] : prev[k] + prod[k][DW+BW-1:BW];
    end
    res_d.out_channel    = s1_q.channel;
    res_d.out_x          = result[0];
    res_d.out_y          = result[1];
    res_d.out_z          = result[2];
    res_d.passed_through = far;
  end

  // Update the channel store as the word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < ftsf_pkg::NumChannels; c++) begin
        for (int k = 0; k < NA; k++) begin
          store_q[c][k] <= '0;
        end
      end
    end else if (xfer && chan_ok) begin
      for (int k = 0; k < NA; k++) begin
        store_q[s1_q.channel][k] <= result[k];
      end
    end
  end

  // A stalled input side means both stages are full and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked full pipeline");

  // A word leaving the input stage always shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> out_valid_q)
    else $error("word lost between input and result register");

  // A zero threshold forces every word through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && thr_q == '0) |=> res_q.passed_through)
    else $error("zero threshold did not force the sample through");

endmodule
